>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ranged random generator.
// No dependencies; include with the bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge, skipped while reset is high.
`define LCG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed")

// Check a property on every rising clock edge, reset included.
`define LCG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed")

`else

`define LCG_ASSERT(lbl, clk, rst, prop)
`define LCG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/lcg_rr_pkg.sv
// Types, constants and the microcode table of the ranged random generator.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`default_nettype none

package lcg_rr_pkg;

   localparam int WORD_W    = 32;
   localparam int RAW_W     = 15;
   localparam int RAW_LSB   = 16;
   localparam int REM_W     = RAW_W + 1;
   localparam int DIV_STEPS = RAW_W;
   localparam int CNT_W     = 4;
   localparam int UPC_W     = 3;

   localparam logic [WORD_W-1:0] LCG_MUL = 32'd214013;
   localparam logic [WORD_W-1:0] LCG_ADD = 32'd2531011;

   localparam logic OPC_DRAW   = 1'b0;
   localparam logic OPC_RESEED = 1'b1;

   // microcode addresses
   localparam logic [UPC_W-1:0] UA_WAIT    = 3'd0;
   localparam logic [UPC_W-1:0] UA_ADVANCE = 3'd1;
   localparam logic [UPC_W-1:0] UA_LOAD    = 3'd2;
   localparam logic [UPC_W-1:0] UA_DIV     = 3'd3;
   localparam logic [UPC_W-1:0] UA_FINISH  = 3'd4;
   localparam logic [UPC_W-1:0] UA_ZERO    = 3'd5;
   localparam logic [UPC_W-1:0] UA_RESEED  = 3'd6;
   localparam logic [UPC_W-1:0] UA_SPARE   = 3'd7;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_ADVANCE,
      OP_LOAD,
      OP_DIV,
      OP_FINISH,
      OP_ZERO,
      OP_RESEED
   } dp_op_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_ALWAYS,
      BR_WAIT,
      BR_SPANZERO,
      BR_LOOP
   } br_type;

   typedef struct packed {
      dp_op_type        op;
      br_type           br;
      logic [UPC_W-1:0] target;
      logic             push;
   } uword_type;

   typedef struct packed {
      dp_op_type op;
      logic      fire;
      logic      push;
   } dp_ctrl_type;

   typedef struct packed {
      logic span_zero;
      logic count_zero;
   } dp_status_type;

   typedef struct packed {
      logic              opcode;
      logic [WORD_W-1:0] seed_value;
      logic [WORD_W-1:0] lower_limit;
      logic [WORD_W-1:0] upper_limit;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] checksum;
      logic              span_error;
   } rsp_word_type;

   // Control store: one word per step.
   function automatic uword_type ucode(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{op: OP_WAIT, br: BR_ALWAYS, target: UA_WAIT, push: 1'b0};
      unique case (addr)
         UA_WAIT:    w = '{op: OP_WAIT,    br: BR_WAIT,     target: UA_RESEED, push: 1'b0};
         UA_ADVANCE: w = '{op: OP_ADVANCE, br: BR_NEXT,     target: UA_WAIT,   push: 1'b0};
         UA_LOAD:    w = '{op: OP_LOAD,    br: BR_SPANZERO, target: UA_ZERO,   push: 1'b0};
         UA_DIV:     w = '{op: OP_DIV,     br: BR_LOOP,     target: UA_DIV,    push: 1'b0};
         UA_FINISH:  w = '{op: OP_FINISH,  br: BR_ALWAYS,   target: UA_WAIT,   push: 1'b1};
         UA_ZERO:    w = '{op: OP_ZERO,    br: BR_ALWAYS,   target: UA_WAIT,   push: 1'b1};
         UA_RESEED:  w = '{op: OP_RESEED,  br: BR_ALWAYS,   target: UA_WAIT,   push: 1'b1};
         default:    w = '{op: OP_WAIT,    br: BR_ALWAYS,   target: UA_WAIT,   push: 1'b0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/lcg_rr_if.sv
// Request and response channel interfaces of the ranged random generator.
// Depends on lcg_rr_pkg for the field widths.
`default_nettype none

interface lcg_rr_req_if import lcg_rr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [WORD_W-1:0] seed_value;
   logic [WORD_W-1:0] lower_limit;
   logic [WORD_W-1:0] upper_limit;

   modport source (output valid, opcode, seed_value, lower_limit, upper_limit,
                   input ready);
   modport sink   (input valid, opcode, seed_value, lower_limit, upper_limit,
                   output ready);
endinterface

interface lcg_rr_rsp_if import lcg_rr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;
   logic [WORD_W-1:0] checksum;
   logic              span_error;

   modport source (output valid, value, checksum, span_error, input ready);
   modport sink   (input valid, value, checksum, span_error, output ready);
endinterface

`default_nettype wire

>>> rtl/lcg_rr_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on lcg_rr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcg_rr_seq import lcg_rr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic          req_opcode,
   input  wire logic          out_busy,
   input  wire dp_status_type status,
   output dp_ctrl_type        ctrl
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   uword_type        uword;
   logic             stall;

   assign uword = ucode(upc_ff);
   // hold a result step while the output register is still occupied
   assign stall = uword.push && out_busy;

   assign ctrl = '{op: uword.op, fire: !stall, push: uword.push};

   always_comb begin
      upc_in = upc_ff;
      if (!stall) begin
         unique case (uword.br)
            BR_NEXT:     upc_in = upc_ff + 1'b1;
            BR_ALWAYS:   upc_in = uword.target;
            BR_WAIT: begin
               if (!accept) begin
                  upc_in = upc_ff;
               end else if (req_opcode == OPC_RESEED) begin
                  upc_in = uword.target;
               end else begin
                  upc_in = upc_ff + 1'b1;
               end
            end
            BR_SPANZERO: upc_in = status.span_zero ? uword.target : upc_ff + 1'b1;
            BR_LOOP:     upc_in = !status.count_zero ? uword.target : upc_ff + 1'b1;
            default:     upc_in = UA_WAIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

   `LCG_ASSERT(a_accept_leaves_wait, clock, reset, accept |=> upc_ff != UA_WAIT);
   `LCG_ASSERT(a_spare_unreached, clock, reset, upc_ff != UA_SPARE);

endmodule

`default_nettype wire

>>> rtl/lcg_rr_datapath.sv
// Datapath: generator state, checksum, operand latches and restoring remainder unit.
// Depends on lcg_rr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcg_rr_datapath import lcg_rr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_ctrl_type   ctrl,
   input  wire logic          accept,
   input  wire req_word_type  req,
   output dp_status_type      status,
   output rsp_word_type       result
);

   logic [WORD_W-1:0] gen_ff,   gen_in;
   logic [WORD_W-1:0] chk_ff,   chk_in;
   logic [WORD_W-1:0] seed_ff,  seed_in;
   logic [WORD_W-1:0] lower_ff, lower_in;
   logic [WORD_W-1:0] span_ff,  span_in;
   logic [RAW_W-1:0]  raw_ff,   raw_in;
   logic [REM_W-1:0]  rem_ff,   rem_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;

   logic [WORD_W-1:0] product;
   logic [REM_W-1:0]  trial;
   logic              trial_fits;
   logic [WORD_W-1:0] sum;

   assign product    = gen_ff * LCG_MUL;
   // shift the next raw bit into the partial remainder
   assign trial      = {rem_ff[REM_W-2:0], raw_ff[RAW_W-1]};
   assign trial_fits = {{(WORD_W-REM_W){1'b0}}, trial} >= span_ff;
   assign sum        = lower_ff + {{(WORD_W-REM_W){1'b0}}, rem_ff};

   assign status = '{span_zero: span_ff == '0, count_zero: cnt_ff == '0};

   always_comb begin
      gen_in   = gen_ff;
      chk_in   = chk_ff;
      seed_in  = seed_ff;
      lower_in = lower_ff;
      span_in  = span_ff;
      raw_in   = raw_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      result   = '{value: '0, checksum: '0, span_error: 1'b0};
      unique case (ctrl.op)
         OP_WAIT: begin
            if (accept) begin
               seed_in  = req.seed_value;
               lower_in = req.lower_limit;
               span_in  = req.upper_limit - req.lower_limit;
            end
         end
         OP_ADVANCE: begin
            gen_in = product + LCG_ADD;
         end
         OP_LOAD: begin
            raw_in = gen_ff[RAW_LSB +: RAW_W];
            rem_in = '0;
            cnt_in = CNT_W'(DIV_STEPS - 1);
         end
         OP_DIV: begin
            raw_in = {raw_ff[RAW_W-2:0], 1'b0};
            rem_in = trial_fits ? trial - span_ff[REM_W-1:0] : trial;
            cnt_in = cnt_ff - 1'b1;
         end
         OP_FINISH: begin
            result = '{value: sum, checksum: chk_ff ^ sum, span_error: 1'b0};
            if (ctrl.fire) begin
               chk_in = chk_ff ^ sum;
            end
         end
         OP_ZERO: begin
            result = '{value: lower_ff, checksum: chk_ff, span_error: 1'b1};
         end
         OP_RESEED: begin
            if (ctrl.fire) begin
               gen_in = seed_ff;
               chk_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
         chk_ff <= '0;
      end else begin
         gen_ff <= gen_in;
         chk_ff <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff  <= seed_in;
      lower_ff <= lower_in;
      span_ff  <= span_in;
      raw_ff   <= raw_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   `LCG_ASSERT(a_rem_below_span, clock, reset,
      (ctrl.op == OP_DIV || ctrl.op == OP_FINISH) |->
      {{(WORD_W-REM_W){1'b0}}, rem_ff} < span_ff);
   `LCG_ASSERT(a_chk_only_on_update, clock, reset,
      (ctrl.op != OP_FINISH && ctrl.op != OP_RESEED) |=> $stable(chk_ff));

endmodule

`default_nettype wire

>>> rtl/lcg_ranged_random_with_checksum.sv
// Top level of the ranged random generator with running checksum.
// Depends on lcg_rr_pkg, lcg_rr_if, lcg_rr_seq and lcg_rr_datapath.
`default_nettype none

// Ranged pseudo-random generator. Each request word either reseeds the 32-bit
// linear congruential generator (state = state * 214013 + 2531011) and clears
// the checksum, or draws a number: the generator advances, bits 30..16 of the
// new state form a 15-bit raw value, and the result is lower_limit plus raw
// modulo (upper_limit - lower_limit), wrapping at 32 bits. Each drawn value is
// XORed into a running checksum that every response word reports. A draw with
// zero span still advances the generator, returns lower_limit with span_error
// set and leaves the checksum alone. Exactly one response word per request.
// Steps: a draw passes through accept, generator advance, raw load, 15
// restoring remainder steps in a shared one-bit-per-cycle unit, and result,
// and loads the response register in its result step; a zero-span draw goes
// from raw load to its own result step, and a reseed loads it after accept.
// One request is worked on at a time; the next one is accepted while the
// previous response still waits in the output register, and a result step
// holds while that register is occupied. The whole flow is a short
// microprogram, so the remainder loop sets the draw rate.

module lcg_ranged_random_with_checksum import lcg_rr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   lcg_rr_req_if.sink    req_chan,
   lcg_rr_rsp_if.source  rsp_chan
);

   dp_ctrl_type   ctrl;
   dp_status_type status;
   req_word_type  req_word;
   rsp_word_type  result;
   logic          accept;
   logic          out_busy;
   logic          push_fire;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff,  rsp_word_in;

   // take a request word only in the wait step of the program
   assign req_chan.ready = (ctrl.op == OP_WAIT);
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_word = '{opcode:      req_chan.opcode,
                       seed_value:  req_chan.seed_value,
                       lower_limit: req_chan.lower_limit,
                       upper_limit: req_chan.upper_limit};

   // output register is busy while it holds a word the sink has not taken
   assign out_busy  = rsp_valid_ff && !rsp_chan.ready;
   assign push_fire = ctrl.push && ctrl.fire;

   lcg_rr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_opcode (req_chan.opcode),
      .out_busy   (out_busy),
      .status     (status),
      .ctrl       (ctrl)
   );

   lcg_rr_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .accept (accept),
      .req    (req_word),
      .status (status),
      .result (result)
   );

   // load a finished word, drop it once taken, hold it otherwise
   always_comb begin
      rsp_valid_in = push_fire || out_busy;
      rsp_word_in  = push_fire ? result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = rsp_word_ff.value;
   assign rsp_chan.checksum   = rsp_word_ff.checksum;
   assign rsp_chan.span_error = rsp_word_ff.span_error;

endmodule

`default_nettype wire

>>> tb/sv/tb_lcg_ranged_random_with_checksum.sv
`timescale 1ns / 100ps
// Self-checking testbench of lcg_ranged_random_with_checksum: draws, reseeds and
// zero-span words under several idle and stall patterns, checked against a predictor.
// Depends on lcg_rr_pkg, the lcg_rr_req_if / lcg_rr_rsp_if interfaces and the RTL.

module tb_lcg_ranged_random_with_checksum;
   import lcg_rr_pkg::*;

   // LCG recurrence and the raw slice that a draw uses
   localparam logic [31:0] RNG_MULT = 32'd214013;
   localparam logic [31:0] RNG_INCR = 32'd2531011;
   localparam int          RAW_HI   = 30;
   localparam int          RAW_LO   = 16;

   // words of random stimulus per phase, and the drain time at the very end
   localparam int RANDOM_PER_PHASE = 182;
   localparam int DRAIN_CYCLES     = 40;

   logic clock;
   logic reset;

   lcg_rr_req_if req_bus ();
   lcg_rr_rsp_if rsp_bus ();

   lcg_ranged_random_with_checksum u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // words waiting to go out, and the responses they are predicted to give
   req_word_type req_backlog[$];
   rsp_word_type rng_results_due[$];

   // predictor copy of the generator and of the running checksum
   logic [31:0] gen_state;
   logic [31:0] csum_state;

   int queued_cnt    = 0;
   int presented_cnt = 0;
   int accepted_cnt  = 0;
   int errors        = 0;

   // idle probability in percent, per side, set by the current phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int           phase;
   req_word_type next_word;
   req_word_type taken_word;
   rsp_word_type due_word;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the predicted state by one request word and return its response.
   function automatic rsp_word_type next_rng_result(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  raw;
      logic [31:0]  span;
      r = '0;
      if (w.opcode == OPC_RESEED) begin
         gen_state  = w.seed_value;
         csum_state = '0;
      end else begin
         // the generator moves on for every draw, zero span included
         gen_state = gen_state * RNG_MULT + RNG_INCR;
         raw       = {17'd0, gen_state[RAW_HI:RAW_LO]};
         span      = w.upper_limit - w.lower_limit;
         if (span == 32'd0) begin
            // no range to map into: return lower, flag it, keep the checksum
            r.value      = w.lower_limit;
            r.span_error = 1'b1;
         end else begin
            r.value    = w.lower_limit + raw % span;
            csum_state = csum_state ^ r.value;
         end
      end
      r.checksum = csum_state;
      return r;
   endfunction

   // Queue a draw; the seed field is ignored, so fill it with noise.
   task automatic queue_draw(input logic [31:0] lower, input logic [31:0] upper);
      req_word_type w;
      w.opcode      = OPC_DRAW;
      w.seed_value  = $urandom;
      w.lower_limit = lower;
      w.upper_limit = upper;
      req_backlog.push_back(w);
      queued_cnt++;
   endtask

   // Queue a reseed; the limits are ignored, so fill them with noise.
   task automatic queue_reseed(input logic [31:0] seed);
      req_word_type w;
      w.opcode      = OPC_RESEED;
      w.seed_value  = seed;
      w.lower_limit = $urandom;
      w.upper_limit = $urandom;
      req_backlog.push_back(w);
      queued_cnt++;
   endtask

   // Mostly draws over spans that exercise the remainder unit in different
   // ways, with reseeds and zero spans mixed in.
   task automatic queue_random_words(input int count);
      int          kind;
      logic [31:0] lo;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         lo   = $urandom;
         if (kind < 10) begin
            queue_reseed($urandom);
         end else if (kind < 20) begin
            queue_draw(lo, lo);
         end else if (kind < 45) begin
            // tiny spans: remainder of almost every raw value
            queue_draw(lo, lo + $urandom_range(1, 16));
         end else if (kind < 65) begin
            // spans around the raw range, where the remainder is often raw itself
            queue_draw(lo, lo + $urandom_range(32'h7FF0, 32'h8010));
         end else begin
            // full random limits, wrapped spans about half the time
            queue_draw(lo, $urandom);
         end
      end
   endtask

   // Request driver: change on the falling edge, hold a word until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (accepted_cnt == presented_cnt) begin
         // the last word went through (or none was up): present the next or idle
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_word = req_backlog.pop_front();
            req_bus.opcode      <= next_word.opcode;
            req_bus.seed_value  <= next_word.seed_value;
            req_bus.lower_limit <= next_word.lower_limit;
            req_bus.upper_limit <= next_word.upper_limit;
            req_bus.valid       <= 1'b1;
            presented_cnt++;
         end else begin
            req_bus.valid       <= 1'b0;
            req_bus.opcode      <= 1'($urandom);
            req_bus.seed_value  <= $urandom;
            req_bus.lower_limit <= $urandom;
            req_bus.upper_limit <= $urandom;
         end
      end
   end

   // Response back-pressure: redraw ready on every falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Request side: predict the response of every accepted word.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken_word.opcode      = req_bus.opcode;
         taken_word.seed_value  = req_bus.seed_value;
         taken_word.lower_limit = req_bus.lower_limit;
         taken_word.upper_limit = req_bus.upper_limit;
         rng_results_due.push_back(next_rng_result(taken_word));
         accepted_cnt++;
      end
   end

   // Response monitor: compare each accepted word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rng_results_due.size() == 0) begin
            $display("%0t: unexpected response word, value %h checksum %h span_error %b",
                     $time, rsp_bus.value, rsp_bus.checksum, rsp_bus.span_error);
            errors++;
         end else begin
            due_word = rng_results_due.pop_front();
            if (rsp_bus.value !== due_word.value) begin
               $display("%0t: value mismatch, expected %h, actual %h",
                        $time, due_word.value, rsp_bus.value);
               errors++;
            end
            if (rsp_bus.checksum !== due_word.checksum) begin
               $display("%0t: checksum mismatch, expected %h, actual %h",
                        $time, due_word.checksum, rsp_bus.checksum);
               errors++;
            end
            if (rsp_bus.span_error !== due_word.span_error) begin
               $display("%0t: span_error mismatch, expected %b, actual %b",
                        $time, due_word.span_error, rsp_bus.span_error);
               errors++;
            end
         end
      end
   end

   initial begin
      // drive every input to a known value before the first edge
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OPC_DRAW;
      req_bus.seed_value  = '0;
      req_bus.lower_limit = '0;
      req_bus.upper_limit = '0;
      rsp_bus.ready       = 1'b0;
      gen_state           = '0;
      csum_state          = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 84;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 84;
            end
            default: begin
               send_idle_pct = 27;
               rsp_stall_pct = 27;
            end
         endcase

         if (phase == 0) begin
            // draw straight from the reset state, no reseed yet
            queue_draw(32'd0, 32'd10);
            // zero span at both ends of the field
            queue_draw(32'd0, 32'd0);
            queue_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            // widest span, and a span of one that returns lower itself
            queue_draw(32'd0, 32'hFFFF_FFFF);
            queue_draw(32'hFFFF_FFFF, 32'd0);
            // wrapped span whose sum wraps past 2^32
            queue_draw(32'hFFFF_FFF0, 32'h0000_0010);
            queue_draw(32'h8000_0000, 32'h7FFF_FFFF);
            queue_draw(32'd0, 32'd1);
            // spans just around the raw maximum
            queue_draw(32'h0000_0100, 32'h0000_8100);
            queue_draw(32'd0, 32'h0000_7FFF);
            queue_reseed(32'd0);
            queue_draw(32'd0, 32'd2);
            queue_reseed(32'hFFFF_FFFF);
            // zero span right after a reseed: checksum still zero
            queue_draw(32'd5, 32'd5);
            queue_draw(32'd0, 32'd3);
            queue_reseed(32'h1234_5678);
            queue_draw(32'hAAAA_AAAA, 32'h5555_5555);
            queue_draw(32'h5555_5555, 32'hAAAA_AAAA);
            queue_reseed($urandom);
            queue_draw(32'd0, 32'hFFFF_FFFF);
         end

         queue_random_words(RANDOM_PER_PHASE);

         // hold until every word of this phase is in and answered
         while (accepted_cnt != queued_cnt || rng_results_due.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rng_results_due.size() != 0) begin
         $display("%0t: %0d response words never arrived", $time, rng_results_due.size());
         errors++;
      end

      if (errors == 0) begin
         $display("tb_lcg_ranged_random_with_checksum passed");
      end else begin
         $display("tb_lcg_ranged_random_with_checksum failed");
      end
      $finish;
   end

   // Drop the run if it hangs; far above the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb_lcg_ranged_random_with_checksum failed");
      $finish;
   end

endmodule
